@@ hw/rtl/root_counters_with_irq_entry_top_assert.svh @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - assertion macros
// Shared property forms for the checker; clocked on rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef ROOT_COUNTERS_WITH_IRQ_ENTRY_TOP_ASSERT_SVH
`define ROOT_COUNTERS_WITH_IRQ_ENTRY_TOP_ASSERT_SVH

// same-cycle implication
`define RCIE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcie assertion failed");

// next-cycle implication
`define RCIE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcie assertion failed");

`endif

@@ hw/rtl/rcie_pkg.sv @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package rcie_pkg;

    localparam int IN_DATA_W   = 88;   // 87 bits of fields, padded to bytes
    localparam int OUT_DATA_W  = 184;  // 183 bits of fields, padded to bytes
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TMR_W       = 16;
    localparam int IRQ_W       = 7;
    localparam int FRAME_CNT_W = 24;   // holds FRAME_PERIOD - 1 at most
    localparam int LINE_CNT_W  = 16;   // holds LINE_PERIOD at most

    // mode bits
    localparam int T0_FULL_BIT = 8;
    localparam int T1_LINE_BIT = 8;
    localparam int T2_STOP_BIT = 0;
    localparam int T2_DIV8_BIT = 9;
    localparam int MODE_IRQ_A  = 4;
    localparam int MODE_IRQ_B  = 6;

    // pending bit positions
    localparam int IRQ_VBLANK = 0;
    localparam int IRQ_TMR0   = 4;
    localparam int IRQ_TMR1   = 5;
    localparam int IRQ_TMR2   = 6;

    // status bits
    localparam int STATUS_IEC = 0;
    localparam int STATUS_IM2 = 10;
    localparam int STATUS_BEV = 22;

    localparam logic [31:0] VEC_BOOT  = 32'hBFC0_0180;
    localparam logic [31:0] VEC_RAM   = 32'h8000_0080;
    localparam logic [31:0] CAUSE_INT = 32'h0000_0400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_T0_MODE,
        REG_T1_MODE,
        REG_T2_MODE,
        REG_T0_LIMIT,
        REG_T1_LIMIT,
        REG_T2_LIMIT,
        REG_IRQ_MASK
    } t_cfg_index;

    typedef struct packed {
        logic [TMR_W-1:0] t0_mode;
        logic [TMR_W-1:0] t1_mode;
        logic [TMR_W-1:0] t2_mode;
        logic [TMR_W-1:0] t0_max;
        logic [TMR_W-1:0] t1_max;
        logic [TMR_W-1:0] t2_max;
        logic [IRQ_W-1:0] irq_mask;
    } t_cfg;

    typedef struct packed {
        logic [15:0]      elapsed_cycles;
        logic [31:0]      current_pc;
        logic [31:0]      current_status;
        logic [IRQ_W-1:0] ack_mask;
    } t_item;

    typedef struct packed {
        logic [IRQ_W-1:0] irq_pending;
        logic             take_exception;
        logic [31:0]      next_pc;
        logic [31:0]      saved_epc;
        logic [31:0]      cause_value;
        logic [31:0]      next_status;
        logic [TMR_W-1:0] timer0_value;
        logic [TMR_W-1:0] timer1_value;
        logic [TMR_W-1:0] timer2_value;
    } t_result;

endpackage

@@ hw/rtl/rcie_cfg.sv @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - configuration registers
// Timer modes, limits and IRQ enable mask, written over the config channel.
// ----------------------------------------------------------------------------
module rcie_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [rcie_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [rcie_pkg::CFG_DATA_W-1:0]     i_data,
    output rcie_pkg::t_cfg                      o_cfg
);

    rcie_pkg::t_cfg r_cfg;
    rcie_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                rcie_pkg::REG_T0_MODE:  n_cfg.t0_mode  = i_data;
                rcie_pkg::REG_T1_MODE:  n_cfg.t1_mode  = i_data;
                rcie_pkg::REG_T2_MODE:  n_cfg.t2_mode  = i_data;
                rcie_pkg::REG_T0_LIMIT: n_cfg.t0_max   = i_data;
                rcie_pkg::REG_T1_LIMIT: n_cfg.t1_max   = i_data;
                rcie_pkg::REG_T2_LIMIT: n_cfg.t2_max   = i_data;
                rcie_pkg::REG_IRQ_MASK: n_cfg.irq_mask = i_data[rcie_pkg::IRQ_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.t0_mode  <= '0;
            r_cfg.t1_mode  <= '0;
            r_cfg.t2_mode  <= '0;
            r_cfg.t0_max   <= '1;
            r_cfg.t1_max   <= '1;
            r_cfg.t2_max   <= '1;
            r_cfg.irq_mask <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/rcie_core.sv @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - counter state and tick logic
// Holds frame, line and timer counters and pending bits; forms one result
// per tick combinationally and commits the new state on i_step.
// ----------------------------------------------------------------------------
module rcie_core #(
    parameter int FRAME_PERIOD = 564480,
    parameter int LINE_PERIOD  = 2170
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rcie_pkg::t_item   i_item,
    input  rcie_pkg::t_cfg    i_cfg,
    output rcie_pkg::t_result o_result
);

    localparam int FW  = rcie_pkg::FRAME_CNT_W;
    localparam int FSW = FW + 1;
    localparam int LW  = rcie_pkg::LINE_CNT_W;
    localparam int TW  = rcie_pkg::TMR_W;
    localparam logic [FSW-1:0] FRAME_LIM  = FSW'(FRAME_PERIOD);
    localparam logic [LW-1:0]  LINE_RELD  = LW'(LINE_PERIOD);

    logic [FW-1:0]               r_frame, n_frame;
    logic [LW-1:0]               r_line,  n_line;
    logic [TW-1:0]               r_t0, n_t0, r_t1, n_t1, r_t2, n_t2;
    logic [rcie_pkg::IRQ_W-1:0]  r_pend, n_pend;

    // free-running advance: {hit, new count}
    function automatic logic [TW:0] tmr_adv(input logic [TW-1:0] cnt,
                                            input logic [TW-1:0] inc,
                                            input logic [TW-1:0] lim);
        logic [TW:0] sum;
        logic        hit;
        sum = {1'b0, cnt} + {1'b0, inc};
        hit = (sum >= {1'b0, lim}) && (cnt < lim);
        return hit ? {1'b1, {TW{1'b0}}} : {1'b0, sum[TW-1:0]};
    endfunction

    logic [15:0]    cyc;
    logic [15:0]    cyc_div8;
    logic [FSW-1:0] frame_sum;
    logic           frame_hit;
    logic [TW:0]    adv0, adv1, adv2;
    logic [LW:0]    line_diff;
    logic           line_tick;
    logic [TW-1:0]  t1_inc;
    logic           t1_wrap;
    logic           hit0, hit1, hit2;
    logic           en0, en1, en2;
    logic           fired;
    logic           take;
    logic [31:0]    status;

    always_comb begin
        cyc      = i_item.elapsed_cycles;
        cyc_div8 = {3'b000, cyc[15:3]};
        status   = i_item.current_status;

        frame_sum = {{(FSW-16){1'b0}}, cyc} + {1'b0, r_frame};
        frame_hit = (frame_sum >= FRAME_LIM);
        n_frame   = frame_hit ? '0 : frame_sum[FW-1:0];

        en0 = i_cfg.t0_mode[rcie_pkg::MODE_IRQ_A] | i_cfg.t0_mode[rcie_pkg::MODE_IRQ_B];
        en1 = i_cfg.t1_mode[rcie_pkg::MODE_IRQ_A] | i_cfg.t1_mode[rcie_pkg::MODE_IRQ_B];
        en2 = i_cfg.t2_mode[rcie_pkg::MODE_IRQ_A] | i_cfg.t2_mode[rcie_pkg::MODE_IRQ_B];

        // timer 0
        adv0 = tmr_adv(r_t0, i_cfg.t0_mode[rcie_pkg::T0_FULL_BIT] ? cyc : cyc_div8,
                       i_cfg.t0_max);
        n_t0 = adv0[TW-1:0];
        hit0 = adv0[TW] & en0;

        // timer 1: free-running or line clock
        adv1      = tmr_adv(r_t1, cyc, i_cfg.t1_max);
        line_diff = {1'b0, r_line} - {1'b0, cyc};
        line_tick = line_diff[LW] || (line_diff == '0);
        t1_inc    = r_t1 + TW'(1);
        t1_wrap   = (t1_inc == i_cfg.t1_max);
        if (i_cfg.t1_mode[rcie_pkg::T1_LINE_BIT]) begin
            n_line = line_tick ? LINE_RELD : line_diff[LW-1:0];
            n_t1   = line_tick ? (t1_wrap ? '0 : t1_inc) : r_t1;
            hit1   = line_tick & t1_wrap & en1;
        end else begin
            n_line = r_line;
            n_t1   = adv1[TW-1:0];
            hit1   = adv1[TW] & en1;
        end

        // timer 2: may be stopped
        adv2 = tmr_adv(r_t2, i_cfg.t2_mode[rcie_pkg::T2_DIV8_BIT] ? cyc_div8 : cyc,
                       i_cfg.t2_max);
        if (i_cfg.t2_mode[rcie_pkg::T2_STOP_BIT]) begin
            n_t2 = r_t2;
            hit2 = 1'b0;
        end else begin
            n_t2 = adv2[TW-1:0];
            hit2 = adv2[TW] & en2;
        end

        n_pend = r_pend & ~i_item.ack_mask;
        n_pend[rcie_pkg::IRQ_VBLANK] = n_pend[rcie_pkg::IRQ_VBLANK] | frame_hit;
        n_pend[rcie_pkg::IRQ_TMR0]   = n_pend[rcie_pkg::IRQ_TMR0] | hit0;
        n_pend[rcie_pkg::IRQ_TMR1]   = n_pend[rcie_pkg::IRQ_TMR1] | hit1;
        n_pend[rcie_pkg::IRQ_TMR2]   = n_pend[rcie_pkg::IRQ_TMR2] | hit2;

        fired = frame_hit | hit0 | hit1 | hit2;
        take  = fired && ((n_pend & i_cfg.irq_mask) != '0)
                && status[rcie_pkg::STATUS_IEC] && status[rcie_pkg::STATUS_IM2];

        o_result.irq_pending    = n_pend;
        o_result.take_exception = take;
        o_result.next_pc        = take ? (status[rcie_pkg::STATUS_BEV] ? rcie_pkg::VEC_BOOT
                                                                       : rcie_pkg::VEC_RAM)
                                       : i_item.current_pc;
        o_result.saved_epc      = take ? i_item.current_pc : '0;
        o_result.cause_value    = take ? rcie_pkg::CAUSE_INT : '0;
        // push the KU/IE stack by one level
        o_result.next_status    = take ? {status[31:6], status[3:0], 2'b00} : status;
        o_result.timer0_value   = n_t0;
        o_result.timer1_value   = n_t1;
        o_result.timer2_value   = n_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_line  <= '0;
            r_t0    <= '0;
            r_t1    <= '0;
            r_t2    <= '0;
            r_pend  <= '0;
        end else if (i_step) begin
            r_frame <= n_frame;
            r_line  <= n_line;
            r_t0    <= n_t0;
            r_t1    <= n_t1;
            r_t2    <= n_t2;
            r_pend  <= n_pend;
        end
    end

endmodule

@@ hw/rtl/root_counters_with_irq_entry_top.sv @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - top level
// Tick-driven frame/line/timer counters with interrupt exception entry.
//
// Usage:
//   - Slave stream: one word per tick (elapsed cycles, PC, status, ack mask).
//   - Master stream: one word per tick with the pending bits, timer counts
//     and the exception entry (vector, EPC, cause, pushed status); tuser
//     flags whether the exception is taken.
//   - Config channel: index/data writes to the seven registers, always ready;
//     write only while no tick is in flight.
//   - Path: a word accepted on the slave side is held in the input register,
//     then in the result register, from which the master side reads it.
//   - Throughput: one word per cycle while the master side does not stall;
//     the counter update between the two registers is combinational.
//   - Reset (synchronous, active low): counters, pending bits and the valid
//     flags of both stages clear; limits go to 0xFFFF, modes and mask to zero.
//   - Master stall: the result register holds; the input register still
//     takes one more word, then s_axis_tready drops until the result drains.
// ----------------------------------------------------------------------------
module root_counters_with_irq_entry_top #(
    parameter int FRAME_PERIOD = 564480,
    parameter int LINE_PERIOD  = 2170
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rcie_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcie_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // tick stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // elapsed_cycles[15:0], current_pc[47:16], current_status[79:48],
    // ack_mask[86:80], zero pad[87]
    input  logic [rcie_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // result stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // irq_pending[6:0], next_pc[38:7], saved_epc[70:39], cause_value[102:71],
    // next_status[134:103], timer0_value[150:135], timer1_value[166:151],
    // timer2_value[182:167], zero pad[183]
    output logic [rcie_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // take_exception[0]
    output logic                                 m_axis_tuser
);

    rcie_pkg::t_cfg    cfg;
    rcie_pkg::t_item   in_item;
    rcie_pkg::t_result core_res;

    logic              r_in_valid, n_in_valid;
    rcie_pkg::t_item   r_in_item;
    logic              r_out_valid, n_out_valid;
    rcie_pkg::t_result r_out;

    logic              in_acc;
    logic              advance;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    rcie_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // unpack tick word
    assign in_item.elapsed_cycles = s_axis_tdata[15:0];
    assign in_item.current_pc     = s_axis_tdata[47:16];
    assign in_item.current_status = s_axis_tdata[79:48];
    assign in_item.ack_mask       = s_axis_tdata[86:80];

    // the input stage moves on when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    // counter state commits once per tick, on the step into the result register
    rcie_core #(
        .FRAME_PERIOD (FRAME_PERIOD),
        .LINE_PERIOD  (LINE_PERIOD)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.take_exception;
    assign m_axis_tdata  = {1'b0,
                            r_out.timer2_value,
                            r_out.timer1_value,
                            r_out.timer0_value,
                            r_out.next_status,
                            r_out.cause_value,
                            r_out.saved_epc,
                            r_out.next_pc,
                            r_out.irq_pending};

endmodule

@@ hw/rtl/rcie_checker.sv @@
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "root_counters_with_irq_entry_top_assert.svh"

module rcie_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [rcie_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input logic                                 m_axis_tuser
);

    logic [31:0] chk_npc;
    logic [31:0] chk_epc;
    logic [31:0] chk_cause;

    assign chk_npc   = m_axis_tdata[38:7];
    assign chk_epc   = m_axis_tdata[70:39];
    assign chk_cause = m_axis_tdata[102:71];

    // taken entry carries the interrupt cause and one of the two vectors
    `RCIE_ASSERT_NOW(a_taken_entry, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        chk_cause == rcie_pkg::CAUSE_INT
        && (chk_npc == rcie_pkg::VEC_BOOT || chk_npc == rcie_pkg::VEC_RAM))

    // no entry: cause and EPC read zero
    `RCIE_ASSERT_NOW(a_idle_entry, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        chk_cause == '0 && chk_epc == '0)

    // pending bits 1..3 are never raised
    `RCIE_ASSERT_NOW(a_unused_pend, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[3:1] == 3'b000)

    // stalled result holds
    `RCIE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind root_counters_with_irq_entry_top rcie_checker u_rcie_checker (.*);

@@ bench/tb_root_counters_with_irq_entry_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Root counters with IRQ entry - testbench
// Streams timer ticks into the block under directed and random settings and
// compares every result word against a cycle-free model of the frame, line
// and timer counters and of the interrupt exception entry.
// ----------------------------------------------------------------------------
module tb_root_counters_with_irq_entry_top;

    localparam int FRAME_CYCLES = 564480;
    localparam int LINE_CYCLES  = 2170;
    localparam int RAND_TICKS   = 1750;

    // ------------------------------------------------------------------------
    // Expected-result model and scoreboard
    // ------------------------------------------------------------------------
    class tick_scoreboard;
        rcie_pkg::t_cfg    regs;
        logic [31:0]       frame_count;
        logic [31:0]       line_countdown;
        logic [15:0]       t0, t1, t2;
        logic [6:0]        pend;
        rcie_pkg::t_result expected_q[$];
        int unsigned       errors;
        int unsigned       reported;

        function new();
            regs           = '0;
            regs.t0_max    = 16'hFFFF;
            regs.t1_max    = 16'hFFFF;
            regs.t2_max    = 16'hFFFF;
            frame_count    = '0;
            line_countdown = '0;
            t0             = '0;
            t1             = '0;
            t2             = '0;
            pend           = '0;
            errors         = 0;
            reported       = 0;
        endfunction

        function void write_reg(rcie_pkg::t_cfg_index idx, logic [15:0] val);
            case (idx)
                rcie_pkg::REG_T0_MODE:  regs.t0_mode  = val;
                rcie_pkg::REG_T1_MODE:  regs.t1_mode  = val;
                rcie_pkg::REG_T2_MODE:  regs.t2_mode  = val;
                rcie_pkg::REG_T0_LIMIT: regs.t0_max   = val;
                rcie_pkg::REG_T1_LIMIT: regs.t1_max   = val;
                rcie_pkg::REG_T2_LIMIT: regs.t2_max   = val;
                rcie_pkg::REG_IRQ_MASK: regs.irq_mask = val[rcie_pkg::IRQ_W-1:0];
                default: ;
            endcase
        endfunction

        // free-running advance: crossing the limit from below wraps to zero
        function logic [15:0] bump(logic [15:0] cnt, logic [15:0] inc,
                                   logic [15:0] lim, output logic hit);
            logic [16:0] sum;
            sum = {1'b0, cnt} + {1'b0, inc};
            hit = (sum >= {1'b0, lim}) && (cnt < lim);
            return hit ? 16'h0 : sum[15:0];
        endfunction

        function logic irq_on(logic [15:0] mode);
            return mode[rcie_pkg::MODE_IRQ_A] | mode[rcie_pkg::MODE_IRQ_B];
        endfunction

        function void post_tick(rcie_pkg::t_item it);
            rcie_pkg::t_result r;
            logic              hit;
            logic              fired;
            logic [15:0]       cyc;
            logic [31:0]       st;
            cyc   = it.elapsed_cycles;
            st    = it.current_status;
            fired = 1'b0;

            pend = pend & ~it.ack_mask;

            frame_count = frame_count + 32'(cyc);
            if (frame_count >= 32'(FRAME_CYCLES)) begin
                frame_count                = '0;
                pend[rcie_pkg::IRQ_VBLANK] = 1'b1;
                fired                      = 1'b1;
            end

            t0 = bump(t0, regs.t0_mode[rcie_pkg::T0_FULL_BIT] ? cyc : {3'b0, cyc[15:3]},
                      regs.t0_max, hit);
            if (hit && irq_on(regs.t0_mode)) begin
                pend[rcie_pkg::IRQ_TMR0] = 1'b1;
                fired                    = 1'b1;
            end

            if (!regs.t1_mode[rcie_pkg::T1_LINE_BIT]) begin
                t1 = bump(t1, cyc, regs.t1_max, hit);
                if (hit && irq_on(regs.t1_mode)) begin
                    pend[rcie_pkg::IRQ_TMR1] = 1'b1;
                    fired                    = 1'b1;
                end
            end else begin
                // line clock: one count per expired line period
                line_countdown = line_countdown - 32'(cyc);
                if (line_countdown == '0 || line_countdown[31]) begin
                    t1 = t1 + 16'd1;
                    if (t1 == regs.t1_max) begin
                        t1 = '0;
                        if (irq_on(regs.t1_mode)) begin
                            pend[rcie_pkg::IRQ_TMR1] = 1'b1;
                            fired                    = 1'b1;
                        end
                    end
                    line_countdown = 32'(LINE_CYCLES);
                end
            end

            if (!regs.t2_mode[rcie_pkg::T2_STOP_BIT]) begin
                t2 = bump(t2,
                          regs.t2_mode[rcie_pkg::T2_DIV8_BIT] ? {3'b0, cyc[15:3]} : cyc,
                          regs.t2_max, hit);
                if (hit && irq_on(regs.t2_mode)) begin
                    pend[rcie_pkg::IRQ_TMR2] = 1'b1;
                    fired                    = 1'b1;
                end
            end

            r.irq_pending    = pend;
            r.take_exception = fired && ((pend & regs.irq_mask) != '0)
                               && st[rcie_pkg::STATUS_IEC] && st[rcie_pkg::STATUS_IM2];
            r.next_pc        = it.current_pc;
            r.saved_epc      = '0;
            r.cause_value    = '0;
            r.next_status    = st;
            if (r.take_exception) begin
                r.next_pc     = st[rcie_pkg::STATUS_BEV] ? rcie_pkg::VEC_BOOT
                                                         : rcie_pkg::VEC_RAM;
                r.saved_epc   = it.current_pc;
                r.cause_value = rcie_pkg::CAUSE_INT;
                r.next_status = {st[31:6], st[3:0], 2'b00};
            end
            r.timer0_value = t0;
            r.timer1_value = t1;
            r.timer2_value = t2;
            expected_q.push_back(r);
        endfunction

        function void cmp(string fname, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch %s: expected %h got %h", fname, e, a);
                end
            end
        endfunction

        function void check_word(rcie_pkg::t_result got);
            rcie_pkg::t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result word %h", got);
                end
                return;
            end
            e = expected_q.pop_front();
            cmp("irq_pending",    32'(e.irq_pending),    32'(got.irq_pending));
            cmp("take_exception", 32'(e.take_exception), 32'(got.take_exception));
            cmp("next_pc",        e.next_pc,             got.next_pc);
            cmp("saved_epc",      e.saved_epc,           got.saved_epc);
            cmp("cause_value",    e.cause_value,         got.cause_value);
            cmp("next_status",    e.next_status,         got.next_status);
            cmp("timer0_value",   32'(e.timer0_value),   32'(got.timer0_value));
            cmp("timer1_value",   32'(e.timer1_value),   32'(got.timer1_value));
            cmp("timer2_value",   32'(e.timer2_value),   32'(got.timer2_value));
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [rcie_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [rcie_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rcie_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rcie_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tuser;

    tick_scoreboard sb = new();
    bit             calm = 1'b0;   // no idling on either side near the end

    root_counters_with_irq_entry_top #(
        .FRAME_PERIOD (FRAME_CYCLES),
        .LINE_PERIOD  (LINE_CYCLES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("FAIL root_counters_with_irq_entry_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure bursts, long open stretches too
    // ------------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Unpack each accepted result word and hand it to the scoreboard.
    always @(posedge i_clk) begin : result_mon
        rcie_pkg::t_result got;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got.irq_pending    = m_axis_tdata[6:0];
            got.take_exception = m_axis_tuser;
            got.next_pc        = m_axis_tdata[38:7];
            got.saved_epc      = m_axis_tdata[70:39];
            got.cause_value    = m_axis_tdata[102:71];
            got.next_status    = m_axis_tdata[134:103];
            got.timer0_value   = m_axis_tdata[150:135];
            got.timer1_value   = m_axis_tdata[166:151];
            got.timer2_value   = m_axis_tdata[182:167];
            sb.check_word(got);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Leaves tvalid high; the caller lowers it when a gap follows.
    task automatic send_tick(rcie_pkg::t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.ack_mask, it.current_status, it.current_pc,
                          it.elapsed_cycles};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.post_tick(it);
    endtask

    // Leaves the config valid high; the caller lowers it after a batch.
    task automatic write_reg(rcie_pkg::t_cfg_index idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic load_all(logic [15:0] m0, logic [15:0] m1, logic [15:0] m2,
                            logic [15:0] l0, logic [15:0] l1, logic [15:0] l2,
                            logic [15:0] mask);
        write_reg(rcie_pkg::REG_T0_MODE,  m0);
        write_reg(rcie_pkg::REG_T1_MODE,  m1);
        write_reg(rcie_pkg::REG_T2_MODE,  m2);
        write_reg(rcie_pkg::REG_T0_LIMIT, l0);
        write_reg(rcie_pkg::REG_T1_LIMIT, l1);
        write_reg(rcie_pkg::REG_T2_LIMIT, l2);
        write_reg(rcie_pkg::REG_IRQ_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every result drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random register set for a new phase; not every register changes.
    task automatic retune();
        logic [15:0] v;
        for (int k = 0; k <= int'(rcie_pkg::REG_IRQ_MASK); k++) begin
            if ($urandom_range(0, 2) != 0) begin
                if (k == int'(rcie_pkg::REG_IRQ_MASK)) begin
                    case ($urandom_range(0, 4))
                        0:       v = 16'h0000;
                        1:       v = 16'h007F;
                        default: v = 16'($urandom);   // upper bits must be dropped
                    endcase
                end else if (k >= int'(rcie_pkg::REG_T0_LIMIT)) begin
                    case ($urandom_range(0, 7))
                        0:       v = 16'h0000;
                        1:       v = 16'hFFFF;
                        2:       v = 16'h0001;
                        3, 4:    v = 16'($urandom_range(1, 300));
                        5:       v = 16'($urandom_range(300, 6000));
                        default: v = 16'($urandom);
                    endcase
                end else begin
                    case ($urandom_range(0, 7))
                        0:       v = 16'h0000;
                        1:       v = 16'hFFFF;
                        default: begin
                            v = 16'($urandom);
                            // lean toward interrupt-raising, running timers
                            if ($urandom_range(0, 9) < 7) v[rcie_pkg::MODE_IRQ_A] = 1'b1;
                            if ($urandom_range(0, 3) != 0) v[rcie_pkg::T2_STOP_BIT] = 1'b0;
                        end
                    endcase
                end
                write_reg(rcie_pkg::t_cfg_index'(k), v);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic rcie_pkg::t_item random_tick();
        rcie_pkg::t_item it;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.elapsed_cycles = 16'($urandom_range(0, 3000));  // around a line
            4:          it.elapsed_cycles = 16'($urandom_range(0, 15));    // small counts that probe the prescaler step
            5:          it.elapsed_cycles = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:    it.elapsed_cycles = 16'($urandom);
        endcase
        it.current_pc     = $urandom;
        it.current_status = $urandom;
        // mostly interrupts enabled, so entries actually happen
        if ($urandom_range(0, 3) != 0) begin
            it.current_status[rcie_pkg::STATUS_IEC] = 1'b1;
            it.current_status[rcie_pkg::STATUS_IM2] = 1'b1;
        end
        it.ack_mask = ($urandom_range(0, 2) == 0) ? 7'($urandom) : 7'h00;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int phase_len;
        bit drained_once;
        sent         = 0;
        drained_once = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed set A: t0 full rate, t1 line clock, t2 eighth rate, all IRQs
        load_all(16'h0150, 16'h0110, 16'h0240, 16'd100, 16'd3, 16'd50, 16'h007F);
        send_tick(rcie_pkg::t_item'{16'h0000, 32'h0000_0000, 32'h0000_0000, 7'h00});
        // boot vector
        send_tick(rcie_pkg::t_item'{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F});
        // RAM vector
        send_tick(rcie_pkg::t_item'{16'd800, 32'h1234_5678, 32'h0000_0401, 7'h00});
        // nothing fires
        send_tick(rcie_pkg::t_item'{16'd1, 32'h1234_567C, 32'h0000_0401, 7'h00});
        // IEC clear
        send_tick(rcie_pkg::t_item'{16'd800, 32'h0000_1000, 32'h0000_0400, 7'h00});
        // ack all
        send_tick(rcie_pkg::t_item'{16'd7, 32'h0000_1004, 32'h0000_0401, 7'h7F});
        // run the frame counter past one frame
        for (int k = 0; k < 8; k++)
            send_tick(rcie_pkg::t_item'{16'hFFFF, 32'($urandom), 32'h0040_0401, 7'h00});
        settle();

        // Directed set B: t0 limit zero (never wraps), t2 stopped, mask off
        load_all(16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
        send_tick(rcie_pkg::t_item'{16'hFFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 7'h00});
        send_tick(rcie_pkg::t_item'{16'd2, 32'h0000_0000, 32'h0000_0401, 7'h00});
        send_tick(rcie_pkg::t_item'{16'hFFFF, 32'h8000_0000, 32'h0000_0401, 7'h7F});
        settle();

        // Directed set C: quiet modes, full limits, all enables
        load_all(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h007F);
        send_tick(rcie_pkg::t_item'{16'hFFFF, 32'h0000_0040, 32'h0040_0401, 7'h00});
        send_tick(rcie_pkg::t_item'{16'h0008, 32'h0000_0044, 32'hFFFF_FFFF, 7'h55});
        send_tick(rcie_pkg::t_item'{16'hFFFF, 32'h0000_0048, 32'h0000_0401, 7'h2A});
        settle();

        // Random phases, each under its own register settings
        while (sent < RAND_TICKS) begin
            retune();
            phase_len = $urandom_range(40, 160);
            for (int k = 0; k < phase_len && sent < RAND_TICKS; k++) begin
                calm = (sent >= RAND_TICKS * 85 / 100);
                send_tick(random_tick());
                sent++;
                if (!drained_once && sent >= RAND_TICKS / 3) begin
                    // sender holds off until the pipe is empty
                    drained_once = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    while (sb.waiting() != 0) @(posedge i_clk);
                end else if (!calm && $urandom_range(0, 4) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("PASS root_counters_with_irq_entry_top");
        else
            $display("FAIL root_counters_with_irq_entry_top");
        $finish;
    end

endmodule
